// ===== hw/rtl/b36f_pkg.sv =====
package b36f_pkg;

    // Value width after the index is sign-extended.
    localparam int VAL_W = 64;
    // A digit or a remainder always fits in 6 bits, because the radix is at most 36.
    localparam int DIG_W = 6;
    // The divider handles this many dividend bits per cycle.
    localparam int DIV_BITS = 16;
    localparam int DIV_CYC = VAL_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_CYC);
    // Width of the reciprocal used to divide one dividend chunk by the radix.
    localparam int RECIP_W = 24;
    // With radix 2, a 64-bit value has 64 digits at most.
    localparam int STACK_DEPTH = VAL_W;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int MAX_RESULTS = 29;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam int CHAR_W = 7;
    localparam int PC_W = 4;

    localparam logic [CHAR_W-1:0] SEP_CHAR = 7'd95;

    // Configuration register indexes.
    localparam logic [7:0] CFG_TYPE = 8'd0;
    localparam logic [7:0] CFG_ACTION = 8'd1;
    localparam logic [7:0] CFG_READY = 8'd2;

    // Micro-operations.
    localparam logic [2:0] OP_WAIT = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_DIV = 3'd2;
    localparam logic [2:0] OP_JNZ = 3'd3;
    localparam logic [2:0] OP_EMIT_DIG = 3'd4;
    localparam logic [2:0] OP_EMIT_SEP = 3'd5;
    localparam logic [2:0] OP_EMIT_ERR = 3'd6;

    // Operand sources for a load.
    localparam logic [1:0] SRC_TYPE = 2'd0;
    localparam logic [1:0] SRC_ACTION = 2'd1;
    localparam logic [1:0] SRC_INDEX = 2'd2;

    typedef struct packed {
        logic [2:0]      op;
        logic [1:0]      src;
        logic            last_num;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic clr;
        logic push;
        logic pop;
    } t_stack_ctl;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIG_W'(10)) begin
            c = CHAR_W'(48) + CHAR_W'(d);
        end else begin
            c = CHAR_W'(55) + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/base36_id_string_formatter.sv =====
// Base-36 identifier string formatter.
// Configuration: write the type number (index 0), the action number (index 1)
// and the ready flag (index 2) on the cfg channel while the block is idle.
// Every request on the input channel carries one signed 32-bit index. It is
// sign-extended to 64 bits and read as unsigned. The output channel then
// returns one ASCII character per result: type, '_', action, '_' and index,
// each in base RADIX, most significant digit first. The final character has
// o_last_char set, and no more than 29 characters are sent. When the ready
// flag is clear, the block sends one character with o_not_ready set instead.
// A small microcode program runs the block. Each digit takes a pass of the
// 16-bit-per-cycle divider over the value and one test for zero. When the
// receiver stalls, the character being sent stays in the output register and
// the program waits at that step. After the last character is loaded, the
// next request is accepted even if that character is not yet taken. Reset
// clears the configuration, the program counter and the output.
module base36_id_string_formatter #(
    parameter int RADIX = 36
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic signed [31:0] i_index_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_out_char,
    output logic        o_last_char,
    output logic        o_not_ready
);

    // Radices outside 2 to 36 are clamped to that range.
    localparam int EFF_RADIX = (RADIX < 2) ? 2 : ((RADIX > 36) ? 36 : RADIX);
    localparam logic [b36f_pkg::DIV_CNT_W-1:0] DIV_LAST =
        b36f_pkg::DIV_CNT_W'(b36f_pkg::DIV_CYC - 1);
    localparam logic [b36f_pkg::CNT_W-1:0] CNT_LAST =
        b36f_pkg::CNT_W'(b36f_pkg::MAX_RESULTS - 1);

    // Configuration registers.
    logic [31:0] r_type_number;
    logic [31:0] r_action_number;
    logic        r_header_ready;

    // Sequencer and datapath registers.
    logic [b36f_pkg::PC_W-1:0]      r_pc, n_pc;
    logic [31:0]                    r_idx, n_idx;
    logic [b36f_pkg::VAL_W-1:0]     r_val, n_val;
    logic [b36f_pkg::DIG_W-1:0]     r_rem, n_rem;
    logic [b36f_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [b36f_pkg::CNT_W-1:0]     r_cnt, n_cnt;

    // Output register.
    logic                        r_out_valid, n_out_valid;
    logic [b36f_pkg::CHAR_W-1:0] r_out_char, n_out_char;
    logic                        r_last_char, n_last_char;
    logic                        r_not_ready, n_not_ready;

    b36f_pkg::t_uword      uw;
    b36f_pkg::t_stack_ctl  stk_ctl;
    logic [b36f_pkg::DIG_W-1:0] stk_top;
    logic [b36f_pkg::SP_W-1:0]  stk_count;
    logic [b36f_pkg::VAL_W-1:0] div_val;
    logic [b36f_pkg::DIG_W-1:0] div_rem;
    logic [b36f_pkg::DIG_W-1:0] div_rem_in;
    logic                       out_free;
    logic                       in_acc;
    logic                       is_last;

    b36f_ucode_rom u_rom (
        .i_pc    (r_pc),
        .o_uword (uw)
    );

    // The remainder starts from zero at the first cycle of each digit.
    assign div_rem_in = (r_div_cnt == '0) ? '0 : r_rem;

    b36f_div_step #(
        .RADIX (EFF_RADIX)
    ) u_div (
        .i_val (r_val),
        .i_rem (div_rem_in),
        .o_val (div_val),
        .o_rem (div_rem)
    );

    b36f_digit_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .i_digit (div_rem),
        .o_top   (stk_top),
        .o_count (stk_count)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_number <= '0;
            r_action_number <= '0;
            r_header_ready <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                b36f_pkg::CFG_TYPE:   r_type_number <= i_cfg_data;
                b36f_pkg::CFG_ACTION: r_action_number <= i_cfg_data;
                b36f_pkg::CFG_READY:  r_header_ready <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // A new request is taken only at the wait step of the program.
    assign o_in_ready = (uw.op == b36f_pkg::OP_WAIT);
    assign in_acc = i_in_valid && o_in_ready;
    // The output register can take a new character when it is empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_pc = r_pc;
        n_idx = r_idx;
        n_val = r_val;
        n_rem = r_rem;
        n_div_cnt = r_div_cnt;
        n_cnt = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_char = r_out_char;
        n_last_char = r_last_char;
        n_not_ready = r_not_ready;
        stk_ctl = '{clr: 1'b0, push: 1'b0, pop: 1'b0};
        is_last = 1'b0;

        case (uw.op)
            b36f_pkg::OP_WAIT: begin
                if (in_acc) begin
                    n_idx = i_index_value;
                    n_cnt = '0;
                    // Digits left over from a truncated string are dropped.
                    stk_ctl.clr = 1'b1;
                    n_pc = r_header_ready ? r_pc + 1'b1 : uw.target;
                end
            end
            b36f_pkg::OP_LOAD: begin
                case (uw.src)
                    b36f_pkg::SRC_TYPE:   n_val = {32'd0, r_type_number};
                    b36f_pkg::SRC_ACTION: n_val = {32'd0, r_action_number};
                    default:              n_val = {{32{r_idx[31]}}, r_idx};
                endcase
                n_div_cnt = '0;
                n_pc = r_pc + 1'b1;
            end
            b36f_pkg::OP_DIV: begin
                n_val = div_val;
                n_rem = div_rem;
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    stk_ctl.push = 1'b1;
                    n_pc = r_pc + 1'b1;
                end
            end
            b36f_pkg::OP_JNZ: begin
                // The quotient is now the next value to divide.
                n_pc = (r_val != '0) ? uw.target : r_pc + 1'b1;
            end
            b36f_pkg::OP_EMIT_DIG: begin
                if (out_free) begin
                    is_last = (uw.last_num && stk_count == b36f_pkg::SP_W'(1))
                              || (r_cnt == CNT_LAST);
                    n_out_valid = 1'b1;
                    n_out_char = b36f_pkg::digit_char(stk_top);
                    n_last_char = is_last;
                    n_not_ready = 1'b0;
                    n_cnt = r_cnt + 1'b1;
                    stk_ctl.pop = 1'b1;
                    if (is_last) begin
                        n_pc = '0;
                    end else if (stk_count == b36f_pkg::SP_W'(1)) begin
                        n_pc = r_pc + 1'b1;
                    end
                end
            end
            b36f_pkg::OP_EMIT_SEP: begin
                if (out_free) begin
                    is_last = (r_cnt == CNT_LAST);
                    n_out_valid = 1'b1;
                    n_out_char = b36f_pkg::SEP_CHAR;
                    n_last_char = is_last;
                    n_not_ready = 1'b0;
                    n_cnt = r_cnt + 1'b1;
                    n_pc = is_last ? '0 : r_pc + 1'b1;
                end
            end
            b36f_pkg::OP_EMIT_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char = '0;
                    n_last_char = 1'b1;
                    n_not_ready = 1'b1;
                    n_pc = '0;
                end
            end
            default: n_pc = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            r_div_cnt <= '0;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            r_div_cnt <= n_div_cnt;
            r_cnt <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_val <= n_val;
        r_rem <= n_rem;
        r_out_char <= n_out_char;
        r_last_char <= n_last_char;
        r_not_ready <= n_not_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_last_char = r_last_char;
    assign o_not_ready = r_not_ready;

`ifndef SYNTHESIS
    // An error result is always the only one, so it must close the string.
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_not_ready) |-> o_last_char)
        else $error("error result without last flag");

    // Once a request is taken, the program must leave the wait step.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sequencer still waiting after accept");

    // The digit stack never grows beyond its depth.
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_count <= b36f_pkg::SP_W'(b36f_pkg::STACK_DEPTH))
        else $error("digit stack overflow");
`endif

endmodule

// ===== hw/rtl/b36f_ucode_rom.sv =====
module b36f_ucode_rom (
    input  logic [b36f_pkg::PC_W-1:0] i_pc,
    output b36f_pkg::t_uword          o_uword
);

    // Each number is loaded, then divided until its quotient is zero. Its
    // digits are then popped from the stack and sent out.
    always_comb begin
        o_uword = '{op: b36f_pkg::OP_WAIT, src: b36f_pkg::SRC_TYPE, last_num: 1'b0,
                    target: 4'd0};
        case (i_pc)
            4'd0:  o_uword.target = 4'd15;
            4'd1:  o_uword.op = b36f_pkg::OP_LOAD;
            4'd2:  o_uword.op = b36f_pkg::OP_DIV;
            4'd3:  begin
                o_uword.op = b36f_pkg::OP_JNZ;
                o_uword.target = 4'd2;
            end
            4'd4:  o_uword.op = b36f_pkg::OP_EMIT_DIG;
            4'd5:  o_uword.op = b36f_pkg::OP_EMIT_SEP;
            4'd6:  begin
                o_uword.op = b36f_pkg::OP_LOAD;
                o_uword.src = b36f_pkg::SRC_ACTION;
            end
            4'd7:  o_uword.op = b36f_pkg::OP_DIV;
            4'd8:  begin
                o_uword.op = b36f_pkg::OP_JNZ;
                o_uword.target = 4'd7;
            end
            4'd9:  o_uword.op = b36f_pkg::OP_EMIT_DIG;
            4'd10: o_uword.op = b36f_pkg::OP_EMIT_SEP;
            4'd11: begin
                o_uword.op = b36f_pkg::OP_LOAD;
                o_uword.src = b36f_pkg::SRC_INDEX;
            end
            4'd12: o_uword.op = b36f_pkg::OP_DIV;
            4'd13: begin
                o_uword.op = b36f_pkg::OP_JNZ;
                o_uword.target = 4'd12;
            end
            4'd14: begin
                o_uword.op = b36f_pkg::OP_EMIT_DIG;
                o_uword.last_num = 1'b1;
            end
            4'd15: o_uword.op = b36f_pkg::OP_EMIT_ERR;
            default: o_uword.op = b36f_pkg::OP_WAIT;
        endcase
    end

endmodule

// ===== hw/rtl/b36f_div_step.sv =====
module b36f_div_step #(
    parameter int RADIX = 36
) (
    input  logic [b36f_pkg::VAL_W-1:0] i_val,
    input  logic [b36f_pkg::DIG_W-1:0] i_rem,
    output logic [b36f_pkg::VAL_W-1:0] o_val,
    output logic [b36f_pkg::DIG_W-1:0] o_rem
);

    localparam int X_W = b36f_pkg::DIG_W + b36f_pkg::DIV_BITS;
    localparam int PROD_W = X_W + b36f_pkg::RECIP_W;
    // With this shift, the rounded-up reciprocal gives the exact quotient for
    // every dividend below 2**X_W.
    localparam int SHIFT = X_W + $clog2(RADIX);
    localparam logic [b36f_pkg::RECIP_W-1:0] RECIP =
        b36f_pkg::RECIP_W'(((64'd1 << SHIFT) + 64'(RADIX) - 64'd1) / 64'(RADIX));
    localparam logic [X_W-1:0] R_EXT = X_W'(RADIX);

    logic [X_W-1:0]                x;
    logic [PROD_W-1:0]             prod;
    logic [b36f_pkg::DIV_BITS-1:0] q;
    logic [X_W-1:0]                qr;

    // One step of long division by the radix, one 16-bit chunk at a time: the
    // top chunk of the value joins the running remainder, and the quotient
    // chunk shifts in at the bottom.
    always_comb begin
        x = {i_rem, i_val[b36f_pkg::VAL_W-1 -: b36f_pkg::DIV_BITS]};
        prod = PROD_W'(x) * PROD_W'(RECIP);
        q = prod[SHIFT +: b36f_pkg::DIV_BITS];
        qr = X_W'(q) * R_EXT;
        o_rem = b36f_pkg::DIG_W'(x - qr);
        o_val = {i_val[b36f_pkg::VAL_W-b36f_pkg::DIV_BITS-1:0], q};
    end

endmodule

// ===== hw/rtl/b36f_digit_stack.sv =====
module b36f_digit_stack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  b36f_pkg::t_stack_ctl       i_ctl,
    input  logic [b36f_pkg::DIG_W-1:0] i_digit,
    output logic [b36f_pkg::DIG_W-1:0] o_top,
    output logic [b36f_pkg::SP_W-1:0]  o_count
);

    logic [b36f_pkg::DIG_W-1:0] r_ent [b36f_pkg::STACK_DEPTH];
    logic [b36f_pkg::SP_W-1:0]  r_count;
    logic [b36f_pkg::SP_W-1:0]  n_count;

    // The stack is a shift line: the top is always entry zero.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_ent[0] <= i_digit;
            for (int i = 1; i < b36f_pkg::STACK_DEPTH; i++) begin
                r_ent[i] <= r_ent[i-1];
            end
        end else if (i_ctl.pop) begin
            for (int i = 0; i < b36f_pkg::STACK_DEPTH - 1; i++) begin
                r_ent[i] <= r_ent[i+1];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.clr) begin
            n_count = '0;
        end else if (i_ctl.push) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top = r_ent[0];
    assign o_count = r_count;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    // The block is built with its default radix. The formatter clamps the radix
    // into 2..36, so the checker does the same.
    localparam int RADIX_SET = 36;
    localparam int EFF_RADIX = (RADIX_SET < 2) ? 2 : ((RADIX_SET > 36) ? 36 : RADIX_SET);

    // Register indexes past the end of the list. Writes to them must be dropped.
    localparam logic [7:0] CFG_FIRST_UNUSED = b36f_pkg::CFG_READY + 8'd1;
    localparam logic [7:0] CFG_TOP_INDEX = 8'hFF;

    localparam logic [7:0] ASCII_ZERO = "0";
    localparam logic [7:0] ASCII_UPPER_A = "A";

    // A config write waits this long after the last character, so that the block is idle.
    localparam int SETTLE_CYCLES = 8;
    // The run ends this many cycles after the last character, so that a stray extra
    // character still shows up.
    localparam int TAIL_CYCLES = 520;
    // Length of the long receiver stall. During it the block backs up into its input.
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int TEXT_W = 8 * b36f_pkg::MAX_RESULTS;

    // One expected character on the output channel.
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       fail;
    } t_id_char;

    // What one row of the directed table does. A request either uses the checker's own
    // prediction, or carries its expected string, or expects the not-ready error.
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REQ,
        ROW_REQ_STR,
        ROW_REQ_ERR
    } t_row_kind;

    // A typed string sits right-justified in the text field. The bytes above it are zero.
    typedef struct packed {
        t_row_kind         kind;
        logic [7:0]        reg_idx;
        logic [31:0]       val;
        logic [TEXT_W-1:0] text;
    } t_dir_row;

    localparam int DIR_ROWS = 25;

    // Directed table. It starts from reset (header not ready) and covers the zero and
    // all-ones headers, the longest string (29 characters), the extreme indexes, the
    // wide write to the ready flag, and writes to indexes that do not exist.
    t_dir_row directed_rows [DIR_ROWS] = '{
        '{ROW_REQ_ERR, '0,                    32'h0000_0000, '0},
        '{ROW_REQ_ERR, '0,                    32'hFFFF_FFFF, '0},
        '{ROW_CFG,     b36f_pkg::CFG_READY,   32'h0000_0001, '0},
        '{ROW_REQ_STR, '0,                    32'h0000_0000, "0_0_0"},
        '{ROW_REQ_STR, '0,                    32'hFFFF_FFFF, "0_0_3W5E11264SGSF"},
        '{ROW_REQ_STR, '0,                    32'h7FFF_FFFF, "0_0_ZIK0ZJ"},
        '{ROW_REQ,     '0,                    32'h8000_0000, '0},
        '{ROW_REQ_STR, '0,                    32'd35,        "0_0_Z"},
        '{ROW_REQ_STR, '0,                    32'd36,        "0_0_10"},
        '{ROW_CFG,     b36f_pkg::CFG_TYPE,    32'hFFFF_FFFF, '0},
        '{ROW_CFG,     b36f_pkg::CFG_ACTION,  32'hFFFF_FFFF, '0},
        '{ROW_REQ_STR, '0,                    32'hFFFF_FFFF, "1Z141Z3_1Z141Z3_3W5E11264SGSF"},
        '{ROW_REQ,     '0,                    32'h8000_0000, '0},
        '{ROW_REQ,     '0,                    32'd12345,     '0},
        '{ROW_CFG,     b36f_pkg::CFG_READY,   32'hFFFF_FFFE, '0},
        '{ROW_REQ_ERR, '0,                    32'd5,         '0},
        '{ROW_CFG,     CFG_FIRST_UNUSED,      32'h0000_0001, '0},
        '{ROW_CFG,     CFG_TOP_INDEX,         32'hFFFF_FFFF, '0},
        '{ROW_REQ_ERR, '0,                    32'd7,         '0},
        '{ROW_CFG,     b36f_pkg::CFG_READY,   32'h8000_0001, '0},
        '{ROW_CFG,     b36f_pkg::CFG_TYPE,    32'd36,        '0},
        '{ROW_CFG,     b36f_pkg::CFG_ACTION,  32'd9,         '0},
        '{ROW_REQ_STR, '0,                    32'd10,        "10_9_A"},
        '{ROW_REQ,     '0,                    32'h5555_5555, '0},
        '{ROW_REQ,     '0,                    32'hAAAA_AAAA, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_index_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [6:0]  o_out_char;
    logic        o_last_char;
    logic        o_not_ready;

    // The checker's copy of the three header registers.
    logic [31:0] hdr_type = '0;
    logic [31:0] hdr_action = '0;
    logic        hdr_ready = 1'b0;

    // Characters still due from the block, oldest first.
    t_id_char id_due [$];

    // Work buffer for one identifier. It is long enough for three radix-2 numbers.
    logic [6:0] id_text [0:135];
    int         id_len;

    // Both sides add random idle cycles while this is set. The sender sets a long
    // stall for the receiver through long_hold_req. The receiver counts it itself.
    bit idle_on = 1'b1;
    int long_hold_req = 0;

    int n_fail = 0;
    int n_requests = 0;
    int n_chars = 0;
    int n_err_results = 0;
    int n_cfg_writes = 0;
    int n_long_holds = 0;

    base36_id_string_formatter #(
        .RADIX(RADIX_SET)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_index_value(i_index_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_char(o_out_char),
        .o_last_char(o_last_char),
        .o_not_ready(o_not_ready)
    );

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    // The longest correct run ends well before this time limit.
    initial begin
        #80_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Appends the digits of a value to the work buffer, most significant digit first.
    // A zero value gives the single digit zero.
    function automatic void append_number(input logic [63:0] v);
        logic [6:0]  rev [0:63];
        logic [63:0] rem;
        int          n;
        n = 0;
        do begin
            rem = v % 64'(EFF_RADIX);
            rev[n] = (rem < 64'd10) ? 7'(ASCII_ZERO + rem) : 7'(ASCII_UPPER_A + rem - 64'd10);
            n++;
            v = v / 64'(EFF_RADIX);
        end while (v != 64'd0);
        while (n > 0) begin
            n--;
            id_text[id_len] = rev[n];
            id_len++;
        end
    endfunction

    // Queues the characters that one accepted index should produce under the current
    // header. The index is sign-extended to 64 bits and printed as an unsigned number.
    function automatic void predict_id(input logic [31:0] idx);
        t_id_char c;
        int       k;
        if (!hdr_ready) begin
            c = '{ch: '0, last: 1'b1, fail: 1'b1};
            id_due.push_back(c);
            return;
        end
        id_len = 0;
        append_number({32'd0, hdr_type});
        id_text[id_len] = b36f_pkg::SEP_CHAR;
        id_len++;
        append_number({32'd0, hdr_action});
        id_text[id_len] = b36f_pkg::SEP_CHAR;
        id_len++;
        append_number({{32{idx[31]}}, idx});
        // The block cuts the string at the result limit. This cannot happen at radix 36.
        if (id_len > b36f_pkg::MAX_RESULTS) begin
            id_len = b36f_pkg::MAX_RESULTS;
        end
        for (k = 0; k < id_len; k++) begin
            c = '{ch: id_text[k], last: (k == id_len - 1), fail: 1'b0};
            id_due.push_back(c);
        end
    endfunction

    // Draws a header number. The mix covers zero, all ones, one-digit values, values of up
    // to three digits, powers of 36 and the values just below them, and wide random values.
    function automatic logic [31:0] pick_header();
        logic [31:0] p;
        int          k;
        case ($urandom_range(0, 5))
            0: begin
                p = '0;
            end
            1: begin
                p = '1;
            end
            2: begin
                p = $urandom_range(0, 35);
            end
            3: begin
                p = $urandom_range(0, 46655);
            end
            4: begin
                p = 32'd1;
                k = $urandom_range(1, 6);
                repeat (k) p = p * 32'd36;
                p = p - 32'($urandom_range(0, 1));
            end
            default: begin
                p = $urandom;
            end
        endcase
        return p;
    endfunction

    // Waits until every due character has arrived, and then for some more cycles.
    task automatic drain_results(input int extra);
        while (id_due.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Writes one register. The block must be idle, so the write waits until all
    // characters are in. Only the low bit of the ready flag is kept. Indexes past the
    // list change nothing.
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        int gap;
        i_in_valid <= 1'b0;
        drain_results(SETTLE_CYCLES);
        gap = idle_on ? $urandom_range(0, 10) : 0;
        repeat (gap) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            b36f_pkg::CFG_TYPE: begin
                hdr_type = data;
            end
            b36f_pkg::CFG_ACTION: begin
                hdr_action = data;
            end
            b36f_pkg::CFG_READY: begin
                hdr_ready = data[0];
            end
            default: begin
            end
        endcase
        n_cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // Offers one index request. Valid stays high from one request to the next when
    // there is no gap, so the block sees requests back to back. When the request is
    // taken, its expected characters are queued: typed in by hand, or predicted.
    task automatic offer_index(input logic [31:0] v, input t_row_kind kind,
                               input logic [TEXT_W-1:0] text);
        int       gap;
        int       hi;
        int       k;
        t_id_char c;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_index_value <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_requests++;
        case (kind)
            ROW_REQ_ERR: begin
                c = '{ch: '0, last: 1'b1, fail: 1'b1};
                id_due.push_back(c);
            end
            ROW_REQ_STR: begin
                // Find the first character of the string. Then queue it down to byte 0.
                hi = 0;
                for (k = 0; k < b36f_pkg::MAX_RESULTS; k++) begin
                    if (text[8*k +: 8] != 8'd0) begin
                        hi = k;
                    end
                end
                for (k = hi; k >= 0; k--) begin
                    c = '{ch: text[8*k +: 7], last: (k == 0), fail: 1'b0};
                    id_due.push_back(c);
                end
            end
            default: begin
                predict_id(v);
            end
        endcase
    endtask

    // Receiver. It waits a random number of cycles before each character, or a long
    // stretch when the sender asks for one. It then takes the character and checks it
    // against the oldest one due.
    initial begin
        int       stall;
        t_id_char want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold_req > 0) begin
                stall = long_hold_req;
                long_hold_req = 0;
                n_long_holds++;
            end else begin
                stall = idle_on ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (id_due.size() == 0) begin
                $error("unexpected character: out_char=%0d last_char=%0b not_ready=%0b",
                       o_out_char, o_last_char, o_not_ready);
                n_fail++;
            end else begin
                want = id_due.pop_front();
                n_chars++;
                if (want.fail) begin
                    n_err_results++;
                end
                if (o_out_char !== want.ch) begin
                    $error("out_char: expected %0d, got %0d", want.ch, o_out_char);
                    n_fail++;
                end
                if (o_last_char !== want.last) begin
                    $error("last_char: expected %0b, got %0b", want.last, o_last_char);
                    n_fail++;
                end
                if (o_not_ready !== want.fail) begin
                    $error("not_ready: expected %0b, got %0b", want.fail, o_not_ready);
                    n_fail++;
                end
            end
        end
    end

    // Sender and phase control.
    initial begin
        int          r;
        int          phase;
        int          n;
        logic [31:0] idx_val;
        logic [31:0] rdy_data;

        // Reset is synchronous.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Rows are walked in order, and config rows wait until the
        // block is idle.
        for (r = 0; r < DIR_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_reg(directed_rows[r].reg_idx, directed_rows[r].val);
            end else begin
                offer_index(directed_rows[r].val, directed_rows[r].kind,
                            directed_rows[r].text);
            end
        end

        // Random part. Each phase loads a new header and then sends a burst of indexes.
        // Most phases have random idle cycles on both sides. Every third phase and phase 1
        // run with no idling at all. Phase 1 also has one long receiver stall, while the sender
        // keeps requests coming, so the block backs up into its input.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_on = ((phase % 3) != 2) && (phase != 1);
            write_reg(b36f_pkg::CFG_TYPE, pick_header());
            write_reg(b36f_pkg::CFG_ACTION, pick_header());
            // The upper data bits are random. Only bit 0 may matter. Phase 5 runs with
            // the header not ready, so every request there fails.
            rdy_data = $urandom;
            rdy_data[0] = (phase != 5) && ($urandom_range(0, 7) != 0);
            write_reg(b36f_pkg::CFG_READY, rdy_data);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(8'($urandom_range(CFG_FIRST_UNUSED, CFG_TOP_INDEX)), $urandom);
            end
            if (phase == 1) begin
                long_hold_req = LONG_HOLD_CYCLES;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 4))
                    0, 1: begin
                        idx_val = $urandom;
                    end
                    2: begin
                        idx_val = $urandom_range(0, 80) - 40;
                    end
                    3: begin
                        idx_val = $urandom >> $urandom_range(1, 31);
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0: idx_val = 32'h0000_0000;
                            1: idx_val = 32'hFFFF_FFFF;
                            2: idx_val = 32'h8000_0000;
                            default: idx_val = 32'h7FFF_FFFF;
                        endcase
                    end
                endcase
                offer_index(idx_val, ROW_REQ, '0);
            end
        end

        i_in_valid <= 1'b0;
        drain_results(TAIL_CYCLES);

        $display("Sent %0d index requests and %0d register writes, with %0d long stall(s).",
                 n_requests, n_cfg_writes, n_long_holds);
        $display("Checked %0d characters, %0d of them not-ready errors.",
                 n_chars, n_err_results);
        if (n_fail == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
